>>> rtl/byte_stream_lookup2_hash_assert.svh
// Assertion macros used by the lookup2 hash mix engine.
`ifndef BYTE_STREAM_LOOKUP2_HASH_ASSERT_SVH
`define BYTE_STREAM_LOOKUP2_HASH_ASSERT_SVH

// The expression holds at every clock edge outside reset.
`define BSLH_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// The antecedent in one cycle implies the consequent in the same cycle.
`define BSLH_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent in one cycle implies the consequent in the next cycle.
`define BSLH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bslh_pkg.sv
// Package with types, constants and mix helpers for the lookup2 hash block.
package bslh_pkg;

    localparam logic [31:0] GOLDEN_RATIO = 32'h9e3779b9;
    localparam int BLOCK_LEN = 12;
    localparam int POS_W = 4;
    localparam int ID_W = 24;
    localparam int QUEUE_DEPTH = 4;
    localparam int MIX_STEPS = 9;
    localparam int STEP_W = 4;

    localparam logic [1:0] LANE_A = 2'd0;
    localparam logic [1:0] LANE_B = 2'd1;
    localparam logic [1:0] LANE_C = 2'd2;

    typedef struct packed {
        logic [31:0] lane_a;
        logic [31:0] lane_b;
        logic [31:0] lane_c;
        logic [31:0] count;
        logic        is_final;
        logic        extra;
    } t_job;

    function automatic logic [4:0] mix_shift(input logic [STEP_W-1:0] step);
        logic [4:0] s;
        case (step)
            4'd0: s = 5'd13;
            4'd1: s = 5'd8;
            4'd2: s = 5'd13;
            4'd3: s = 5'd12;
            4'd4: s = 5'd16;
            4'd5: s = 5'd5;
            4'd6: s = 5'd3;
            4'd7: s = 5'd10;
            4'd8: s = 5'd15;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    function automatic logic [1:0] mix_lane(input logic [STEP_W-1:0] step);
        logic [1:0] l;
        case (step)
            4'd0, 4'd3, 4'd6: l = LANE_A;
            4'd1, 4'd4, 4'd7: l = LANE_B;
            default: l = LANE_C;
        endcase
        return l;
    endfunction

endpackage

>>> rtl/bslh_front.sv
// Front end: gathers bytes into blocks and forms mix requests.
module bslh_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_data_byte,
    input  logic            i_byte_valid,
    input  logic            i_last,
    output logic            o_job_push,
    output bslh_pkg::t_job  o_job
);

    logic [7:0] r_bytes [bslh_pkg::BLOCK_LEN];
    logic [bslh_pkg::POS_W-1:0] r_pos;
    logic [31:0] r_count;

    logic [7:0] w_blk [bslh_pkg::BLOCK_LEN];
    logic [7:0] w_tail [bslh_pkg::BLOCK_LEN];
    logic [31:0] w_cnt;
    logic [bslh_pkg::POS_W-1:0] w_tlen;
    logic w_full;

    always_comb begin
        for (int i = 0; i < bslh_pkg::BLOCK_LEN; i++) begin
            w_blk[i] = (i_byte_valid && r_pos == bslh_pkg::POS_W'(i)) ? i_data_byte : r_bytes[i];
            w_tail[i] = (bslh_pkg::POS_W'(i) < w_tlen) ? w_blk[i] : 8'h00;
        end
    end

    assign w_cnt  = r_count + 32'(i_byte_valid);
    assign w_tlen = r_pos + bslh_pkg::POS_W'(i_byte_valid);
    assign w_full = i_byte_valid && (r_pos == bslh_pkg::POS_W'(bslh_pkg::BLOCK_LEN - 1));

    always_comb begin
        o_job.count = w_cnt;
        if (w_full) begin
            o_job.lane_a   = {w_blk[3], w_blk[2], w_blk[1], w_blk[0]};
            o_job.lane_b   = {w_blk[7], w_blk[6], w_blk[5], w_blk[4]};
            o_job.lane_c   = {w_blk[11], w_blk[10], w_blk[9], w_blk[8]};
            o_job.is_final = i_last;
            o_job.extra    = i_last;
        end else begin
            o_job.lane_a   = {w_tail[3], w_tail[2], w_tail[1], w_tail[0]};
            o_job.lane_b   = {w_tail[7], w_tail[6], w_tail[5], w_tail[4]};
            o_job.lane_c   = {w_tail[10], w_tail[9], w_tail[8], 8'h00} + w_cnt;
            o_job.is_final = 1'b1;
            o_job.extra    = 1'b0;
        end
    end

    assign o_job_push = i_accept && (w_full || i_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_pos   <= (i_last || w_full) ? '0 : w_tlen;
            r_count <= i_last ? '0 : w_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && i_byte_valid) begin
            r_bytes[r_pos] <= i_data_byte;
        end
    end

endmodule

>>> rtl/bslh_queue.sv
// Small request queue between the front end and the mix engine.
module bslh_queue #(
    parameter int DEPTH = bslh_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bslh_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output bslh_pkg::t_job  o_job,
    output logic            o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bslh_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic w_do_push;
    logic w_do_pop;

    assign o_full    = (r_cnt == CW'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign o_job     = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

>>> rtl/bslh_mix.sv
// Back end: mix engine that runs one mix step per cycle and holds the result.
`include "byte_stream_lookup2_hash_assert.svh"
module bslh_mix (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_job_empty,
    input  bslh_pkg::t_job           i_job,
    output logic                     o_job_pop,
    input  logic                     i_pop,
    output logic                     o_empty,
    output logic [31:0]              o_hash_value,
    output logic [bslh_pkg::ID_W-1:0] o_message_id
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MIX  = 2'd1;
    localparam logic [1:0] ST_ADD  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] r_state;
    logic [bslh_pkg::STEP_W-1:0] r_step;
    logic [31:0] r_a;
    logic [31:0] r_b;
    logic [31:0] r_c;
    logic [31:0] r_count;
    logic r_final;
    logic r_extra;
    logic r_out_valid;
    logic [31:0] r_hash;

    logic [4:0] w_sh;
    logic [31:0] n_a;
    logic [31:0] n_b;
    logic [31:0] n_c;
    logic w_load_out;

    assign w_sh = bslh_pkg::mix_shift(r_step);

    always_comb begin
        n_a = r_a;
        n_b = r_b;
        n_c = r_c;
        case (bslh_pkg::mix_lane(r_step))
            bslh_pkg::LANE_A: n_a = (r_a - r_b - r_c) ^ (r_c >> w_sh);
            bslh_pkg::LANE_B: n_b = (r_b - r_c - r_a) ^ (r_a << w_sh);
            default:          n_c = (r_c - r_a - r_b) ^ (r_b >> w_sh);
        endcase
    end

    assign o_job_pop  = (r_state == ST_IDLE) && !i_job_empty;
    assign w_load_out = (r_state == ST_DONE) && (!r_out_valid || i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_a         <= bslh_pkg::GOLDEN_RATIO;
            r_b         <= bslh_pkg::GOLDEN_RATIO;
            r_c         <= '0;
            r_final     <= 1'b0;
            r_extra     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_job_empty) begin
                        r_a     <= r_a + i_job.lane_a;
                        r_b     <= r_b + i_job.lane_b;
                        r_c     <= r_c + i_job.lane_c;
                        r_final <= i_job.is_final;
                        r_extra <= i_job.extra;
                        r_step  <= '0;
                        r_state <= ST_MIX;
                    end
                end
                ST_MIX: begin
                    r_a <= n_a;
                    r_b <= n_b;
                    r_c <= n_c;
                    if (r_step == bslh_pkg::STEP_W'(bslh_pkg::MIX_STEPS - 1)) begin
                        r_step <= '0;
                        if (r_extra) begin
                            r_state <= ST_ADD;
                        end else if (r_final) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                ST_ADD: begin
                    r_c     <= r_c + r_count;
                    r_extra <= 1'b0;
                    r_step  <= '0;
                    r_state <= ST_MIX;
                end
                ST_DONE: begin
                    if (w_load_out) begin
                        r_a     <= bslh_pkg::GOLDEN_RATIO;
                        r_b     <= bslh_pkg::GOLDEN_RATIO;
                        r_c     <= '0;
                        r_final <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_count <= i_job.count;
        end
        if (w_load_out) begin
            r_hash <= r_c;
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_hash_value = r_hash;
    assign o_message_id = r_hash[bslh_pkg::ID_W-1:0];

    `BSLH_ASSERT_ALWAYS(a_step_range, r_step < bslh_pkg::STEP_W'(bslh_pkg::MIX_STEPS), "mix step out of range")
    `BSLH_ASSERT_SAME(a_done_final, r_state == ST_DONE, r_final && !r_extra, "result stage without final request")
    `BSLH_ASSERT_NEXT(a_take_starts, o_job_pop, r_state == ST_MIX && r_step == '0, "request taken without mix start")

endmodule

>>> rtl/byte_stream_lookup2_hash.sv
// Top level of the byte-stream lookup2 hash block.
//
//  channel  | handshake    | payload
//  ---------+--------------+--------------------------------------------
//  input    | push / full  | i_data_byte, i_byte_valid, i_last
//  result   | empty / pop  | o_hash_value, o_message_id
//
// The front end takes one byte per cycle while the request queue is not
// full and forwards a request every twelve bytes and at each message end.
// The mix engine takes a request only when idle; a message end on a full
// block gets a second mix pass after the byte count is added to c.
// Reset is synchronous and active low, and there is no clearing pass.
// A full request queue raises full; a waiting result stalls only the engine.
module byte_stream_lookup2_hash #(
    parameter int QUEUE_DEPTH = bslh_pkg::QUEUE_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [7:0]                i_data_byte,
    input  logic                      i_byte_valid,
    input  logic                      i_last,
    output logic                      empty,
    input  logic                      pop,
    output logic [31:0]               o_hash_value,
    output logic [bslh_pkg::ID_W-1:0] o_message_id
);

    logic w_accept;
    logic w_job_push;
    bslh_pkg::t_job w_job_in;
    bslh_pkg::t_job w_job_out;
    logic w_job_empty;
    logic w_job_pop;

    assign w_accept = push && !full;

    bslh_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_data_byte  (i_data_byte),
        .i_byte_valid (i_byte_valid),
        .i_last       (i_last),
        .o_job_push   (w_job_push),
        .o_job        (w_job_in)
    );

    bslh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_job   (w_job_in),
        .o_full  (full),
        .i_pop   (w_job_pop),
        .o_job   (w_job_out),
        .o_empty (w_job_empty)
    );

    bslh_mix u_mix (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_empty  (w_job_empty),
        .i_job        (w_job_out),
        .o_job_pop    (w_job_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_hash_value (o_hash_value),
        .o_message_id (o_message_id)
    );

endmodule
